### src/chess_position_bit_packer_unit_macros.svh
// ----------------------------------------------------------------------------
// chess position bit packer assertion macros
// concurrent check wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef CHESS_POSITION_BIT_PACKER_UNIT_MACROS_SVH
`define CHESS_POSITION_BIT_PACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same cycle implication
`define CBP_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cbp check failed");
// next cycle implication
`define CBP_IMPLIES_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cbp check failed");
`else
`define CBP_IMPLIES(label, clk, rst_n, ante, cons)
`define CBP_IMPLIES_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/cbp_pkg.sv
// ----------------------------------------------------------------------------
// cbp_pkg
// shared types, codes and the piece code table of the position packer
// ----------------------------------------------------------------------------
package cbp_pkg;

	localparam logic [1:0] OP_HEADER  = 2'd0;
	localparam logic [1:0] OP_SQUARE  = 2'd1;
	localparam logic [1:0] OP_TRAILER = 2'd2;

	localparam logic [2:0] KIND_EMPTY  = 3'd0;
	localparam logic [2:0] KIND_PAWN   = 3'd1;
	localparam logic [2:0] KIND_KNIGHT = 3'd2;
	localparam logic [2:0] KIND_BISHOP = 3'd3;
	localparam logic [2:0] KIND_ROOK   = 3'd4;
	localparam logic [2:0] KIND_QUEEN  = 3'd5;

	localparam logic [3:0] CODE_PAWN   = 4'b0001;
	localparam logic [3:0] CODE_KNIGHT = 4'b0011;
	localparam logic [3:0] CODE_BISHOP = 4'b0101;
	localparam logic [3:0] CODE_ROOK   = 4'b0111;
	localparam logic [3:0] CODE_QUEEN  = 4'b1001;

	// longest bit string of one item (trailer with en passant square)
	localparam int BUF_W = 34;
	localparam int REM_W = 6;

	typedef struct packed {
		logic [1:0]  opcode;
		logic        turn;
		logic [5:0]  white_king_square;
		logic [5:0]  black_king_square;
		logic [2:0]  piece_kind;
		logic        piece_color;
		logic [3:0]  castle_rights;
		logic        ep_valid;
		logic [5:0]  ep_target;
		logic [6:0]  rule50;
		logic [15:0] ply_count;
	} item_t;

	typedef struct packed {
		logic load;
		logic pack;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic pack_done;
		logic flush_done;
		logic trailer;
	} sts_t;

	function automatic logic [3:0] piece_code(input logic [2:0] kind);
		logic [3:0] code;
		case (kind)
			KIND_PAWN:   code = CODE_PAWN;
			KIND_KNIGHT: code = CODE_KNIGHT;
			KIND_BISHOP: code = CODE_BISHOP;
			KIND_ROOK:   code = CODE_ROOK;
			KIND_QUEEN:  code = CODE_QUEEN;
			default:     code = 4'b0000;
		endcase
		return code;
	endfunction

endpackage

### src/cbp_ctrl.sv
// ----------------------------------------------------------------------------
// cbp_ctrl
// sequencer: accept an item, pack its bits, flush the record after a trailer
// ----------------------------------------------------------------------------
module cbp_ctrl import cbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PACK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.load  = in_valid && (state_q == ST_IDLE);
	assign cmd.pack  = (state_q == ST_PACK);
	assign cmd.flush = (state_q == ST_FLUSH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_PACK;
			end
			ST_PACK: begin
				if (sts.pack_done) state_d = sts.trailer ? ST_FLUSH : ST_IDLE;
			end
			ST_FLUSH: begin
				if (sts.flush_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

### src/cbp_datapath.sv
// ----------------------------------------------------------------------------
// cbp_datapath
// item bit buffer, byte assembler, record counters and output register
// ----------------------------------------------------------------------------
module cbp_datapath import cbp_pkg::*; #(
	parameter int RECORD_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  item_t       item,
	output sts_t        sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [4:0]  out_index,
	output logic        out_last,
	output logic        out_overflow
);

	localparam int BD_W = $clog2(RECORD_BYTES);
	localparam logic [BD_W-1:0] LAST_BYTE = BD_W'(RECORD_BYTES - 1);

	logic [BUF_W-1:0] buf_q;
	logic [REM_W-1:0] rem_q;
	logic [7:0]       pend_q;
	logic [2:0]       pcnt_q;
	logic [BD_W-1:0]  bd_q;
	logic             ovf_q;
	logic             held_q;
	logic             trailer_q;
	logic             out_valid_q;

	logic [3:0]       avail;
	logic [3:0]       take;
	logic [7:0]       mask;
	logic [7:0]       new_bits;
	logic [3:0]       sum;
	logic             full;
	logic             last_slot;
	logic             slot_free;
	logic             pack_emit;
	logic             pack_fire;
	logic             flush_fire;
	logic [15:0]      fullmove;
	logic [15:0]      ply_diff;
	logic [BUF_W-1:0] load_buf;
	logic [REM_W-1:0] load_rem;

	assign avail     = 4'd8 - {1'b0, pcnt_q};
	assign take      = (rem_q > {2'b00, avail}) ? avail : rem_q[3:0];
	assign mask      = 8'hFF >> (4'd8 - take);
	assign new_bits  = (buf_q[7:0] & mask) << pcnt_q;
	assign sum       = {1'b0, pcnt_q} + take;
	assign full      = sum[3];
	assign last_slot = (bd_q == LAST_BYTE);
	assign slot_free = !out_valid_q || out_ready;

	assign pack_emit  = !held_q && full && !last_slot;
	assign pack_fire  = cmd.pack && (!pack_emit || slot_free);
	assign flush_fire = cmd.flush && slot_free;

	assign sts.pack_done  = pack_fire && (held_q || (rem_q == {2'b00, take}));
	assign sts.flush_done = flush_fire && last_slot;
	assign sts.trailer    = trailer_q;

	assign ply_diff = item.ply_count - {15'd0, item.turn};
	assign fullmove = (item.ply_count < {15'd0, item.turn}) ? 16'd1 :
		16'd1 + {1'b0, ply_diff[15:1]};

	always_comb begin
		load_buf = '0;
		load_rem = '0;
		case (item.opcode)
			OP_HEADER: begin
				load_buf = BUF_W'({item.black_king_square, item.white_king_square,
					item.turn});
				load_rem = REM_W'(13);
			end
			OP_SQUARE: begin
				if (item.piece_kind == KIND_EMPTY) begin
					load_rem = REM_W'(1);
				end else if (item.piece_kind <= KIND_QUEEN) begin
					load_buf = BUF_W'({item.piece_color, piece_code(item.piece_kind)});
					load_rem = REM_W'(5);
				end
			end
			OP_TRAILER: begin
				if (item.ep_valid) begin
					load_buf = {item.rule50[6], fullmove, item.rule50[5:0], item.ep_target,
						1'b1, item.castle_rights};
					load_rem = REM_W'(34);
				end else begin
					load_buf = BUF_W'({item.rule50[6], fullmove, item.rule50[5:0], 1'b0,
						item.castle_rights});
					load_rem = REM_W'(28);
				end
			end
			default: begin
				load_buf = '0;
				load_rem = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			pend_q    <= '0;
			pcnt_q    <= '0;
			bd_q      <= '0;
			ovf_q     <= 1'b0;
			held_q    <= 1'b0;
			trailer_q <= 1'b0;
		end else if (cmd.load) begin
			rem_q     <= load_rem;
			trailer_q <= (item.opcode == OP_TRAILER);
			if (item.opcode == OP_HEADER) begin
				pend_q <= '0;
				pcnt_q <= '0;
				bd_q   <= '0;
				ovf_q  <= 1'b0;
				held_q <= 1'b0;
			end
		end else if (pack_fire) begin
			if (held_q) begin
				if (rem_q != '0) ovf_q <= 1'b1;
				rem_q <= '0;
			end else begin
				rem_q  <= rem_q - {2'b00, take};
				pcnt_q <= sum[2:0];
				if (full && last_slot) begin
					pend_q <= pend_q | new_bits;
					held_q <= 1'b1;
				end else if (full) begin
					pend_q <= '0;
					bd_q   <= bd_q + 1'b1;
				end else begin
					pend_q <= pend_q | new_bits;
				end
			end
		end else if (flush_fire) begin
			pend_q <= '0;
			pcnt_q <= '0;
			if (last_slot) begin
				bd_q      <= '0;
				ovf_q     <= 1'b0;
				held_q    <= 1'b0;
				trailer_q <= 1'b0;
			end else begin
				bd_q <= bd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) buf_q <= load_buf;
		else if (pack_fire) buf_q <= buf_q >> take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if ((pack_fire && pack_emit) || flush_fire) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pack_fire && pack_emit) begin
			out_byte     <= pend_q | new_bits;
			out_index    <= 5'(bd_q);
			out_last     <= 1'b0;
			out_overflow <= ovf_q;
		end else if (flush_fire) begin
			out_byte     <= pend_q;
			out_index    <= 5'(bd_q);
			out_last     <= last_slot;
			out_overflow <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### src/chess_position_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// chess_position_bit_packer_unit
// packs a header, 64 board squares and a trailer into one fixed byte record
// ----------------------------------------------------------------------------
// Each input beat is accepted only while the unit is idle, and its bits (13 for a
// header, up to 5 for a square, 28 or 34 for a trailer) then enter the byte
// assembler at up to one byte boundary per cycle; the next beat waits until
// they are all packed. After a trailer the record is padded with zeros and
// flushed, its remaining bytes leaving in order, before a new beat is taken.
// The single output register sets the pace when the sink stalls. Bytes leave
// as they fill, the last one only with the trailer; bits beyond the record are
// dropped and flagged on the last byte. No clearing pass follows reset.
`include "chess_position_bit_packer_unit_macros.svh"

module chess_position_bit_packer_unit import cbp_pkg::*; #(
	parameter int RECORD_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// turn, white_king_square, black_king_square, piece_kind, piece_color,
	// castle_rights, ep_valid, ep_target, rule50, ply_count, zero fill
	input  logic [55:0] s_tdata,
	// opcode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// byte_value, byte_index, zero fill
	output logic [15:0] m_tdata,
	output logic        m_tlast,
	// overflow
	output logic [0:0]  m_tuser
);

	item_t      item;
	cmd_t       cmd;
	sts_t       sts;
	logic [7:0] out_byte;
	logic [4:0] out_index;
	logic       out_overflow;

	assign item.opcode            = s_tuser;
	assign item.turn              = s_tdata[0];
	assign item.white_king_square = s_tdata[6:1];
	assign item.black_king_square = s_tdata[12:7];
	assign item.piece_kind        = s_tdata[15:13];
	assign item.piece_color       = s_tdata[16];
	assign item.castle_rights     = s_tdata[20:17];
	assign item.ep_valid          = s_tdata[21];
	assign item.ep_target         = s_tdata[27:22];
	assign item.rule50            = s_tdata[34:28];
	assign item.ply_count         = s_tdata[50:35];

	cbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cbp_datapath #(
		.RECORD_BYTES (RECORD_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.sts          (sts),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_byte     (out_byte),
		.out_index    (out_index),
		.out_last     (m_tlast),
		.out_overflow (out_overflow)
	);

	assign m_tdata = {3'b000, out_index, out_byte};
	assign m_tuser = out_overflow;

	`CBP_IMPLIES(a_last_index, clk, arst_n, m_tvalid && m_tlast, m_tdata[12:8] == 5'(RECORD_BYTES - 1))
	`CBP_IMPLIES(a_ovf_only_last, clk, arst_n, m_tvalid && !m_tlast, !m_tuser[0])
	`CBP_IMPLIES_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the chess position bit packer: a directed table then
// random records, bytes checked in order against a bit-level packing predictor
// ----------------------------------------------------------------------------
module tb import cbp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RECORD_BYTES = 32;
	localparam int RANDOM_ITEMS = 300;
	localparam int CALM_FROM    = 240;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 64;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [2:0] KIND_KING  = 3'd6;
	localparam logic [2:0] KIND_SPARE = 3'd7;

	typedef struct packed {
		logic [7:0] value;
		logic [4:0] index;
		logic       last;
		logic       ovf;
	} out_byte_t;

	typedef struct packed {
		item_t     it;
		logic      fixed;
		logic      fx_n;
		out_byte_t fx;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;

	chess_position_bit_packer_unit #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// packing predictor state
	logic [7:0] acc_bits;
	int         acc_cnt;
	int         bytes_out;
	bit         spill_seen;
	bit         tail_full;
	out_byte_t  item_bytes[$];
	out_byte_t  bytes_due[$];

	int         fails;
	int         cycles;
	bit         calm;
	out_byte_t  got;
	out_byte_t  want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic item_t mk(logic [1:0] op, logic side, logic [5:0] wk, logic [5:0] bk,
		logic [2:0] kind, logic color, logic [3:0] castle, logic epv, logic [5:0] eps,
		logic [6:0] r50, logic [15:0] ply);
		item_t it;
		it = '{op, side, wk, bk, kind, color, castle, epv, eps, r50, ply};
		return it;
	endfunction

	function automatic item_t rnd_item(logic [1:0] op);
		item_t       it;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		it.opcode = op;
		return it;
	endfunction

	function automatic void clear_record();
		acc_bits   = '0;
		acc_cnt    = 0;
		bytes_out  = 0;
		spill_seen = 1'b0;
		tail_full  = 1'b0;
	endfunction

	function automatic void push_byte(logic is_last);
		out_byte_t b;
		b.value = acc_bits;
		b.index = bytes_out[4:0];
		b.last  = is_last;
		b.ovf   = spill_seen;
		item_bytes.push_back(b);
	endfunction

	function automatic void shift_bit(logic b);
		if (tail_full || bytes_out >= RECORD_BYTES) begin
			spill_seen = 1'b1;
			return;
		end
		acc_bits[acc_cnt] = b;
		acc_cnt++;
		if (acc_cnt == 8) begin
			acc_cnt = 0;
			if (bytes_out + 1 >= RECORD_BYTES) begin
				tail_full = 1'b1;
			end else begin
				push_byte(1'b0);
				bytes_out++;
				acc_bits = '0;
			end
		end
	endfunction

	function automatic void shift_field(logic [31:0] v, int n);
		int k;
		for (k = 0; k < n; k++)
			shift_bit(v[k]);
	endfunction

	// bytes produced by one accepted beat land in item_bytes
	function automatic void pack_position_item(item_t it);
		logic [3:0] code;
		int         ply;
		int         side;
		int         fullmove;
		item_bytes.delete();
		case (it.opcode)
			OP_HEADER: begin
				clear_record();
				shift_bit(it.turn);
				shift_field(32'(it.white_king_square), 6);
				shift_field(32'(it.black_king_square), 6);
			end
			OP_SQUARE: begin
				if (it.piece_kind == KIND_EMPTY) begin
					shift_bit(1'b0);
				end else if (it.piece_kind <= KIND_QUEEN) begin
					code = (it.piece_kind == KIND_QUEEN) ? CODE_QUEEN :
						4'(2 * int'(it.piece_kind) - 1);
					shift_field(32'(code), 4);
					shift_bit(it.piece_color);
				end
			end
			OP_TRAILER: begin
				shift_field(32'(it.castle_rights), 4);
				shift_bit(it.ep_valid);
				if (it.ep_valid)
					shift_field(32'(it.ep_target), 6);
				shift_field(32'(it.rule50[5:0]), 6);
				ply  = int'(it.ply_count);
				side = int'(it.turn);
				fullmove = (ply < side) ? 1 : 1 + (ply - side) / 2;
				shift_field(32'(fullmove), 16);
				shift_bit(it.rule50[6]);
				if (!tail_full) begin
					while (bytes_out + 1 < RECORD_BYTES) begin
						push_byte(1'b0);
						bytes_out++;
						acc_bits = '0;
						acc_cnt  = 0;
					end
				end
				push_byte(1'b1);
				clear_record();
			end
			default: ;
		endcase
	endfunction

	task automatic note_mismatch(string msg);
		fails++;
		if (fails <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[7:0], m_tdata[12:8], m_tlast, m_tuser[0]};
			if (bytes_due.size() == 0) begin
				note_mismatch($sformatf("unexpected beat: value %h index %0d last %b ovf %b",
					got.value, got.index, got.last, got.ovf));
			end else begin
				want = bytes_due.pop_front();
				if (got.value !== want.value || got.index !== want.index ||
					got.last !== want.last || got.ovf !== want.ovf) begin
					note_mismatch($sformatf(
						"byte mismatch: exp value %h index %0d last %b ovf %b, got %h %0d %b %b",
						want.value, want.index, want.last, want.ovf,
						got.value, got.index, got.last, got.ovf));
				end
			end
		end
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				m_tready <= 1'b1;
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(60, 200)) @(posedge clk);
				else
					repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	task automatic send(item_t it);
		s_tvalid <= 1'b1;
		s_tuser  <= it.opcode;
		s_tdata  <= {5'd0, it.ply_count, it.rule50, it.ep_target, it.ep_valid,
			it.castle_rights, it.piece_color, it.piece_kind, it.black_king_square,
			it.white_king_square, it.turn};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drive_item(item_t it);
		send(it);
		pack_position_item(it);
		foreach (item_bytes[k])
			bytes_due.push_back(item_bytes[k]);
		gap();
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bytes_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		row_t  plan[$];
		row_t  r;
		item_t it;
		int    n_rand;
		int    nsq;
		int    p_empty;
		int    sel;
		int    drain;
		int    j;
		bit    first_rec;
		bit    paused;

		fails     = 0;
		cycles    = 0;
		calm      = 1'b0;
		first_rec = 1'b1;
		paused    = 1'b0;
		clear_record();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_HEADER;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back('{mk(OP_HEADER, 1, 63, 63, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1,
			'{8'hFF, 5'd0, 1'b0, 1'b0}});
		plan.push_back('{mk(OP_UNUSED, 1, 63, 63, 7, 1, 15, 1, 63, 127, 16'hFFFF), 1'b1, 1'b0,
			'0});
		plan.push_back('{mk(OP_SQUARE, 0, 0, 0, KIND_QUEEN, 1, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_SQUARE, 0, 0, 0, KIND_EMPTY, 1, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_SQUARE, 0, 0, 0, KIND_PAWN, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_SQUARE, 0, 0, 0, KIND_KNIGHT, 1, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_SQUARE, 0, 0, 0, KIND_BISHOP, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_SQUARE, 0, 0, 0, KIND_ROOK, 1, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_SQUARE, 0, 0, 0, KIND_KING, 1, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_SQUARE, 0, 0, 0, KIND_SPARE, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_TRAILER, 1, 0, 0, 0, 0, 15, 1, 63, 127, 16'hFFFF), 1'b0, 1'b0,
			'0});
		// trailer with no header, ply below side to move
		plan.push_back('{mk(OP_TRAILER, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1,
			'{8'h00, 5'd0, 1'b0, 1'b0}});
		plan.push_back('{mk(OP_SQUARE, 0, 0, 0, KIND_QUEEN, 1, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		// header in the middle of a record drops it
		plan.push_back('{mk(OP_HEADER, 0, 4, 60, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_SQUARE, 0, 0, 0, KIND_ROOK, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_TRAILER, 0, 0, 0, 0, 0, 5, 1, 0, 64, 1), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_HEADER, 1, 42, 21, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b0, '0});
		plan.push_back('{mk(OP_TRAILER, 0, 0, 0, 0, 0, 10, 0, 42, 63, 16'hFFFF), 1'b0, 1'b0,
			'0});

		foreach (plan[k]) begin
			r = plan[k];
			send(r.it);
			pack_position_item(r.it);
			if (r.fixed) begin
				if (r.fx_n)
					bytes_due.push_back(r.fx);
			end else begin
				foreach (item_bytes[q])
					bytes_due.push_back(item_bytes[q]);
			end
			gap();
		end
		hold_until_drained();

		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			calm = (n_rand >= CALM_FROM);
			if (!paused && n_rand >= 150) begin
				paused = 1'b1;
				hold_until_drained();
			end
			sel = $urandom_range(0, 9);
			if (sel == 0 && !first_rec) begin
				it = rnd_item(2'($urandom_range(0, 3)));
				drive_item(it);
				if (it.opcode != OP_UNUSED)
					n_rand++;
			end else begin
				case ($urandom_range(0, 7))
					0, 1:    nsq = 64;
					2:       nsq = $urandom_range(40, 70);
					default: nsq = $urandom_range(0, 16);
				endcase
				p_empty = $urandom_range(0, 100);
				if (first_rec) begin
					nsq     = 64;
					p_empty = 0;
				end
				if (nsq > RANDOM_ITEMS - n_rand)
					nsq = RANDOM_ITEMS - n_rand;
				first_rec = 1'b0;
				if (sel != 1) begin
					drive_item(rnd_item(OP_HEADER));
					n_rand++;
				end
				for (j = 0; j < nsq; j++) begin
					it = rnd_item(OP_SQUARE);
					if ($urandom_range(0, 99) < p_empty)
						it.piece_kind = KIND_EMPTY;
					else
						it.piece_kind = 3'($urandom_range(1, 7));
					// a stray header now and then breaks the record
					if (sel == 2 && j == nsq / 2)
						it = rnd_item(OP_HEADER);
					drive_item(it);
					n_rand++;
				end
				if (sel != 3) begin
					drive_item(rnd_item(OP_TRAILER));
					n_rand++;
				end
			end
		end
		calm = 1'b1;
		drive_item(rnd_item(OP_TRAILER));
		s_tvalid <= 1'b0;

		drain = 0;
		while (bytes_due.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bytes_due.size() != 0)
			note_mismatch($sformatf("%0d expected bytes never arrived", bytes_due.size()));

		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
